// ----- rtl/core/flac_lpc_pkg.sv -----
// flac_lpc_pkg: shared widths, register indexes and item kinds for the
// linear-prediction restore block. No dependencies; used by the core, by
// its port checker and by the bench.
package flac_lpc_pkg;

  localparam int MAX_ORDER = 32;
  localparam int TAP_W     = $clog2(MAX_ORDER);   // tap address bits
  localparam int ORDER_W   = 6;                   // predictor_order register
  localparam int SHIFT_W   = 5;                   // quant_shift register
  localparam int COEF_W    = 16;
  localparam int SAMPLE_W  = 32;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int ACC_W     = 64;

  localparam int IN_DATA_W  = 56;   // 5 + 16 + 32 bits, padded to whole bytes
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // input word layout in tdata
  localparam int CIDX_LSB  = 0;
  localparam int CVAL_LSB  = CIDX_LSB + TAP_W;
  localparam int RESID_LSB = CVAL_LSB + COEF_W;

  // tuser bit positions
  localparam int USER_KIND  = 0;
  localparam int USER_START = 1;

  // item kinds
  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE  = 2'd2;

endpackage

// ----- rtl/core/flac_lpc_restore.sv -----
// flac_lpc_restore: FLAC linear-prediction sample restore core.
// Depends on flac_lpc_pkg for widths, register indexes and item kinds.
// Holds the coefficient memory, the sample history and the MAC sequencer.

// Turns a stream of FLAC residuals back into 32-bit samples. Two kinds of
// input word share the slave port, told apart by tuser[0]: a coefficient
// word (kind 0) writes one 16-bit tap into the coefficient memory and gives
// no result; a sample word (kind 1) gives exactly one output word. tuser[1]
// marks the first sample of a block. The first predictor_order samples of a
// block are warm-up values and pass through unchanged; every later sample
// is residual + (sum of coef[j] * s[n-order+j]) >>> quant_shift, with the
// sum wrapping at 32 bits (wide_accumulate = 0) or kept in 64 bits
// (wide_accumulate = 1), and the result wrapping to 32 bits. A coefficient
// word leaves the slave side ready for the next word; a sample word keeps
// it busy until the result enters the output register. Predictions use
// the single 16x32 multiply-accumulate unit, which walks one tap per cycle
// behind a registered coefficient memory read and a registered product.
// The slave side is ready only between items and never in reset, but a
// finished sample waits in the output register, so the next word is taken
// while the master side stalls. Write the configuration registers only
// while the block is idle; coefficient taps must be written before a
// prediction uses them. There is no clearing pass after reset.
module flac_lpc_restore (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [flac_lpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flac_lpc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: coef_index[4:0], coef_value[20:5], residual[52:21], zeros[55:53]
  input  logic [flac_lpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind[0], block_start[1]
  input  logic [flac_lpc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // result words
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: sample_out[31:0]
  output logic [flac_lpc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;

  logic [2:0] state;

  // configuration registers
  logic [flac_lpc_pkg::ORDER_W-1:0] predictor_order;
  logic [flac_lpc_pkg::SHIFT_W-1:0] quant_shift;
  logic                             wide_accumulate;

  // storage
  logic [flac_lpc_pkg::COEF_W-1:0]   coef_mem [flac_lpc_pkg::MAX_ORDER];
  logic [flac_lpc_pkg::SAMPLE_W-1:0] history  [flac_lpc_pkg::MAX_ORDER]; // [0] newest
  logic [flac_lpc_pkg::ORDER_W-1:0]  block_position;

  // datapath registers
  logic [flac_lpc_pkg::ORDER_W-1:0]         tap_cnt;
  logic                                     rd_v;
  logic                                     mul_v;
  logic signed [flac_lpc_pkg::COEF_W-1:0]   coef_rd;
  logic signed [flac_lpc_pkg::SAMPLE_W-1:0] hist_rd;
  logic signed [flac_lpc_pkg::PROD_W-1:0]   prod;
  logic [flac_lpc_pkg::ACC_W-1:0]           acc;
  logic [flac_lpc_pkg::SAMPLE_W-1:0]        resid;
  logic [flac_lpc_pkg::SAMPLE_W-1:0]        result;

  // input word fields
  logic                               in_kind;
  logic                               in_start;
  logic [flac_lpc_pkg::TAP_W-1:0]     in_cidx;
  logic [flac_lpc_pkg::COEF_W-1:0]    in_cval;
  logic [flac_lpc_pkg::SAMPLE_W-1:0]  in_resid;

  logic                               in_fire;
  logic                               out_free;
  logic [flac_lpc_pkg::ORDER_W-1:0]   order_eff;
  logic [flac_lpc_pkg::ORDER_W-1:0]   pos_eff;
  logic [flac_lpc_pkg::ORDER_W-1:0]   hist_idx;
  logic [flac_lpc_pkg::ACC_W-1:0]     shifted64;
  logic [flac_lpc_pkg::SAMPLE_W-1:0]  shifted32;
  logic [flac_lpc_pkg::SAMPLE_W-1:0]  pred;

  assign in_kind  = s_axis_tuser[flac_lpc_pkg::USER_KIND];
  assign in_start = s_axis_tuser[flac_lpc_pkg::USER_START];
  assign in_cidx  = s_axis_tdata[flac_lpc_pkg::CIDX_LSB +: flac_lpc_pkg::TAP_W];
  assign in_cval  = s_axis_tdata[flac_lpc_pkg::CVAL_LSB +: flac_lpc_pkg::COEF_W];
  assign in_resid = s_axis_tdata[flac_lpc_pkg::RESID_LSB +: flac_lpc_pkg::SAMPLE_W];

  // take nothing while reset is held
  assign cfg_ready     = !rst;
  assign s_axis_tready = !rst && (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // clamp the order into 1..MAX_ORDER
  always_comb begin
    if (predictor_order == '0) begin
      order_eff = flac_lpc_pkg::ORDER_W'(1);
    end else if (predictor_order > flac_lpc_pkg::ORDER_W'(flac_lpc_pkg::MAX_ORDER)) begin
      order_eff = flac_lpc_pkg::ORDER_W'(flac_lpc_pkg::MAX_ORDER);
    end else begin
      order_eff = predictor_order;
    end
  end

  // a block start restarts the warm-up count
  assign pos_eff  = in_start ? '0 : block_position;
  // tap j pairs with history[order-1-j], the sample order-j places back
  assign hist_idx = order_eff - flac_lpc_pkg::ORDER_W'(1) - tap_cnt;

  // arithmetic shift of the prediction sum, then add the residual
  assign shifted64 = $signed(acc) >>> quant_shift;
  assign shifted32 = $signed(acc[flac_lpc_pkg::SAMPLE_W-1:0]) >>> quant_shift;
  assign pred      = wide_accumulate ? shifted64[flac_lpc_pkg::SAMPLE_W-1:0] : shifted32;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_order <= flac_lpc_pkg::ORDER_W'(1);
      quant_shift     <= '0;
      wide_accumulate <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        flac_lpc_pkg::REG_ORDER: predictor_order <= cfg_data;
        flac_lpc_pkg::REG_SHIFT: quant_shift     <= cfg_data[flac_lpc_pkg::SHIFT_W-1:0];
        flac_lpc_pkg::REG_WIDE:  wide_accumulate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // coefficient memory: one write port, registered read at the tap counter
  always_ff @(posedge clk) begin
    if (in_fire && in_kind == flac_lpc_pkg::KIND_COEF) begin
      coef_mem[in_cidx] <= in_cval;
    end
    coef_rd <= coef_mem[tap_cnt[flac_lpc_pkg::TAP_W-1:0]];
  end

  // MAC datapath: read, multiply, accumulate, one register between each
  always_ff @(posedge clk) begin
    hist_rd <= history[hist_idx[flac_lpc_pkg::TAP_W-1:0]];
    prod    <= coef_rd * hist_rd;
    if (in_fire) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + {{(flac_lpc_pkg::ACC_W - flac_lpc_pkg::PROD_W){prod[flac_lpc_pkg::PROD_W-1]}},
                    prod};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      block_position <= '0;
      tap_cnt        <= '0;
      rd_v           <= 1'b0;
      mul_v          <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      for (int i = 0; i < flac_lpc_pkg::MAX_ORDER; i++) begin
        history[i] <= '0;
      end
    end else begin
      mul_v <= rd_v;
      // raise valid as a finished sample moves out, drop it once taken
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          rd_v <= 1'b0;
          if (in_fire && in_kind == flac_lpc_pkg::KIND_SAMPLE) begin
            resid   <= in_resid;
            tap_cnt <= '0;
            if (pos_eff < order_eff) begin
              // warm-up: pass the word through
              block_position <= pos_eff + flac_lpc_pkg::ORDER_W'(1);
              result         <= in_resid;
              state          <= ST_DONE;
            end else begin
              block_position <= pos_eff;
              state          <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          // issue one tap a cycle, then drain the read and multiply stages
          if (tap_cnt < order_eff) begin
            rd_v    <= 1'b1;
            tap_cnt <= tap_cnt + flac_lpc_pkg::ORDER_W'(1);
          end else begin
            rd_v <= 1'b0;
            if (!rd_v && !mul_v) begin
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          result <= resid + pred;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free, then push the history
          if (out_free) begin
            m_axis_tdata  <= result;
            history[0]    <= result;
            for (int i = 1; i < flac_lpc_pkg::MAX_ORDER; i++) begin
              history[i] <= history[i-1];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/flac_lpc_chk.sv -----
// flac_lpc_chk: port-level checker for flac_lpc_restore.
// Depends on flac_lpc_pkg; bound to flac_lpc_restore at the end of this file.
module flac_lpc_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [flac_lpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [flac_lpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [flac_lpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [flac_lpc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [flac_lpc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic in_fire;
  logic in_sample;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_sample = s_axis_tuser[flac_lpc_pkg::USER_KIND] == flac_lpc_pkg::KIND_SAMPLE;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed under stall");

  // no word appears in the cycle straight after an accept
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_fire && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result word appeared too early");

  // a sample word occupies the core
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_sample |=> !s_axis_tready)
    else $error("accepted a word while a sample is in progress");

  // the first sample of a block passes through unchanged
  a_warmup: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_sample && s_axis_tuser[flac_lpc_pkg::USER_START] && !m_axis_tvalid
    |-> ##2 m_axis_tvalid && m_axis_tdata ==
        $past(s_axis_tdata[flac_lpc_pkg::RESID_LSB +: flac_lpc_pkg::SAMPLE_W], 2))
    else $error("warm-up sample not passed through");

endmodule

bind flac_lpc_restore flac_lpc_chk u_flac_lpc_chk (.*);

// ----- bench/flac_lpc_restore_checker.sv -----
// flac_lpc_restore_checker: watches the configuration, input and result
// channels of the restore core, predicts every restored sample and checks it.
// Depends on flac_lpc_pkg for widths, field positions and register indexes.
`timescale 1ns / 100ps

module flac_lpc_restore_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [flac_lpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flac_lpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // tdata: coef_index, coef_value, residual, zero padding
  input  logic [flac_lpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind, block_start
  input  logic [flac_lpc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: sample_out
  input  logic [flac_lpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                                  fail_count,
  output int                                  expected_left
);
  import flac_lpc_pkg::*;

  logic signed [COEF_W-1:0] taps [MAX_ORDER];
  logic [SAMPLE_W-1:0]      past [MAX_ORDER];   // past[0] is the newest sample
  int                       block_pos;
  logic [ORDER_W-1:0]       order_reg;
  logic [SHIFT_W-1:0]       shift_reg;
  logic                     wide_reg;
  logic [SAMPLE_W-1:0]      restored_q [$];
  int                       mismatches = 0;

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Restore one sample and advance the history and block position.
  function automatic logic [SAMPLE_W-1:0] restore_sample(input logic start,
                                                         input logic [SAMPLE_W-1:0] resid);
    int                        ord;
    logic [SAMPLE_W-1:0]       acc32;
    logic signed [SAMPLE_W-1:0] narrow;
    logic signed [ACC_W-1:0]   acc64;
    logic signed [ACC_W-1:0]   prod;
    logic [SAMPLE_W-1:0]       smp;
    ord = (order_reg == 0) ? 1 : ((int'(order_reg) > MAX_ORDER) ? MAX_ORDER : int'(order_reg));
    if (start) block_pos = 0;
    if (block_pos < ord) begin
      smp = resid;
      block_pos++;
    end else begin
      acc32 = '0;
      acc64 = '0;
      for (int j = 0; j < ord; j++) begin
        prod  = taps[j] * $signed(past[ord - 1 - j]);
        acc32 = acc32 + prod[SAMPLE_W-1:0];
        acc64 = acc64 + prod;
      end
      if (wide_reg) begin
        acc64 = acc64 >>> shift_reg;
        smp   = resid + acc64[SAMPLE_W-1:0];
      end else begin
        narrow = acc32;
        narrow = narrow >>> shift_reg;
        smp    = resid + narrow;
      end
    end
    for (int k = MAX_ORDER - 1; k > 0; k--) past[k] = past[k - 1];
    past[0] = smp;
    return smp;
  endfunction

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        taps[k] = '0;
        past[k] = '0;
      end
      block_pos = 0;
      order_reg = ORDER_W'(1);
      shift_reg = '0;
      wide_reg  = 1'b0;
      restored_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORDER: order_reg = cfg_data[ORDER_W-1:0];
          REG_SHIFT: shift_reg = cfg_data[SHIFT_W-1:0];
          REG_WIDE:  wide_reg  = cfg_data[0];
          default: ;
        endcase
      end
      // check results before queueing new ones, so a stray word never
      // meets an expectation raised at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (restored_q.size() == 0) begin
          report_mismatch("unexpected sample", m_axis_tdata, '0);
        end else begin
          want = restored_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("sample_out", m_axis_tdata, want);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[USER_KIND] == KIND_COEF)
          taps[s_axis_tdata[CIDX_LSB +: TAP_W]] = s_axis_tdata[CVAL_LSB +: COEF_W];
        else
          restored_q.push_back(restore_sample(s_axis_tuser[USER_START],
                                              s_axis_tdata[RESID_LSB +: SAMPLE_W]));
      end
    end
    expected_left <= restored_q.size();
    fail_count    <= mismatches;
  end

endmodule

// ----- bench/tb_flac_lpc_restore.sv -----
// tb_flac_lpc_restore: stimulus and verdict for the linear-prediction restore
// core; directed words first, then randomised phases over many register settings.
// Depends on flac_lpc_pkg, flac_lpc_restore and flac_lpc_restore_checker.
`timescale 1ns / 100ps

module tb_flac_lpc_restore;
  import flac_lpc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // coef_index, coef_value, residual, padding
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // kind, block_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // sample_out

  int   fail_count;
  int   expected_left;
  logic steady = 1'b0;                        // no idling on either side while set
  logic tap_written [MAX_ORDER];

  always #5 clk = ~clk;

  flac_lpc_restore DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  flac_lpc_restore_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Receiver: stall about a third of the cycles, except in steady stretches.
  always @(negedge clk) begin
    if (steady) m_axis_tready = 1'b1;
    else        m_axis_tready = ($urandom_range(0, 99) >= 33);
  end

  // Hard stop. The slowest correct run (order 32 everywhere, longest gaps and
  // stalls) stays well below a fifth of this.
  initial begin
    #(4_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return SAMPLE_W'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 3))
      0:       return COEF_W'($urandom_range(0, 128)) - COEF_W'(64);
      1:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int eff_order(input int v);
    if (v == 0) return 1;
    if (v > MAX_ORDER) return MAX_ORDER;
    return v;
  endfunction

  // Present one word and hold it until the core takes it. Fields that the
  // kind does not use carry whatever the caller gives, usually noise.
  task automatic send_word(input logic kind, input logic [TAP_W-1:0] idx,
                           input logic [COEF_W-1:0] val, input logic start,
                           input logic [SAMPLE_W-1:0] resid);
    logic [IN_DATA_W-1:0] word;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = IN_DATA_W'({$urandom, $urandom});
      s_axis_tuser  = 2'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    word = '0;
    word[CIDX_LSB +: TAP_W]     = idx;
    word[CVAL_LSB +: COEF_W]    = val;
    word[RESID_LSB +: SAMPLE_W] = resid;
    s_axis_tdata  = word;
    s_axis_tuser  = '0;
    s_axis_tuser[USER_KIND]  = kind;
    s_axis_tuser[USER_START] = start;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (kind == KIND_COEF) tap_written[idx] = 1'b1;
  endtask

  task automatic send_coef(input int idx, input logic [COEF_W-1:0] val);
    send_word(KIND_COEF, TAP_W'(idx), val, 1'($urandom), $urandom);
  endtask

  task automatic send_sample(input logic start, input logic [SAMPLE_W-1:0] resid);
    send_word(KIND_SAMPLE, TAP_W'($urandom), 16'($urandom), start, resid);
  endtask

  // Drop valid and hold until every expected sample has come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_left != 0) @(posedge clk);
  endtask

  // Registers change only while the core is idle: drain, then give a trailing
  // coefficient word time to land before writing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    drain();
    repeat (50) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = CFG_DATA_W'($urandom);
  endtask

  // Never let a prediction read a tap that was never written.
  task automatic load_taps(input int upto);
    for (int t = 0; t < upto; t++)
      if (!tap_written[t]) send_coef(t, rand_coef());
  endtask

  // One randomised phase: set the registers, then mostly well-formed blocks
  // with random content, mixed with coefficient rewrites and stray starts.
  task automatic run_phase(input int order_val, input int shift_val, input int wide_val,
                           input int n_words, input logic pause_midway);
    int ord;
    int blk_left;
    int r;
    logic start;
    write_reg(REG_ORDER, order_val);
    write_reg(REG_SHIFT, shift_val);
    write_reg(REG_WIDE, wide_val);
    ord = eff_order(order_val);
    load_taps(ord);
    // sometimes carry on the previous block under the new order
    blk_left = ($urandom_range(0, 2) == 0) ? 8 : 0;
    for (int i = 0; i < n_words; i++) begin
      if (pause_midway && i == n_words / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_coef($urandom_range(0, MAX_ORDER - 1), rand_coef());
      end else begin
        start = 1'b0;
        if (blk_left <= 0 || r < 13) begin
          start    = 1'b1;
          blk_left = ord + $urandom_range(1, 24);
        end
        send_sample(start, rand_sample());
        blk_left--;
      end
    end
  endtask

  initial begin
    int order_val;
    int shift_val;
    for (int t = 0; t < MAX_ORDER; t++) tap_written[t] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings (order 1, no shift, narrow). The first block has no start
    // flag, yet its first sample passes through as warm-up from reset.
    send_coef(0, 16'h7FFF);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b0, 32'h0000_0000);

    // Order 4 with the widest shift and the wide accumulator, extreme taps.
    write_reg(REG_ORDER, 4);
    write_reg(REG_SHIFT, 31);
    write_reg(REG_WIDE, 1);
    send_coef(1, 16'h8000);
    send_coef(2, 16'hFFFF);
    send_coef(3, 16'h0001);
    send_sample(1'b1, 32'h8000_0000);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b0, 32'h0000_0001);

    // Shrink the order mid-block and go back to the wrapping accumulator.
    write_reg(REG_ORDER, 2);
    write_reg(REG_SHIFT, 0);
    write_reg(REG_WIDE, 0);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_coef(31, 16'h8000);
    send_sample(1'b1, 32'hFFFF_FFFF);

    // Order zero behaves as order one.
    write_reg(REG_ORDER, 0);
    send_sample(1'b0, 32'h1234_5678);
    send_sample(1'b1, 32'h8765_4321);
    send_sample(1'b0, 32'hFFFF_FFFF);

    // Random phases: largest order, orders past the largest, order zero and
    // one, then a spread weighted towards small orders.
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       order_val = MAX_ORDER;
        1:       order_val = $urandom_range(MAX_ORDER + 1, 63);
        2:       order_val = 0;
        3:       order_val = 1;
        default: order_val = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                         : $urandom_range(0, 63);
      endcase
      if (p % 3 == 0) shift_val = (p % 2 == 0) ? 31 : 0;
      else            shift_val = $urandom_range(0, 31);
      steady = (p == 4 || p == 5);
      run_phase(order_val, shift_val, p % 2, 58, p == 6);
    end
    steady = 1'b0;

    // Let the last samples out, then give the core room to show a stray word.
    drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_left == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
